FILE: rtl/assert_macros.svh
// ============================================================================
// Assertion macros
// Shorthand for the concurrent assertions of the box blur checker.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is active.
`define BBC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is active.
`define BBC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define BBC_ASSERT_RST(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/bbc_pkg.sv
// ============================================================================
// Box blur package
// Constants, register indexes and shared types of the cropped box blur.
// ============================================================================
package bbc_pkg;

  localparam int MAX_WIDTH_DEF = 2048;
  localparam int RADIUS_DEF    = 25;

  localparam int PIX_W      = 8;
  localparam int ROW_W      = 12;
  localparam int HGT_W      = 13;
  localparam int WID_W      = 12;
  localparam int MAX_HEIGHT = 4096;

  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  localparam logic [WID_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [HGT_W-1:0] HEIGHT_RESET = 13'd480;

  localparam int MID_DEPTH   = 4;
  localparam int OUT_DEPTH   = 8;
  localparam int PIPE_STAGES = 4;

  typedef struct packed {
    logic row_first;
    logic row_full;
    logic col_first;
    logic col_full;
    logic emit;
    logic frame_end;
  } bbc_flags_t;

  localparam int FLAGS_W = $bits(bbc_flags_t);

endpackage

FILE: rtl/bbc_ram.sv
// ============================================================================
// Generic RAM
// One write port and one read port with registered read data.
// ============================================================================
module bbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

FILE: rtl/bbc_fifo.sv
// ============================================================================
// Small queue
// Register-based first-in first-out queue with a fill count.
// ============================================================================
module bbc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  logic [WIDTH-1:0]         wdata,
  output logic                     full,
  input  logic                     pop,
  output logic [WIDTH-1:0]         rdata,
  output logic                     empty,
  output logic [$clog2(DEPTH):0]   count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = AW + 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wp_r, rp_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rdata   = mem_r[rp_r];
  assign count   = cnt_r;
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
      end
      if (do_pop) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

FILE: rtl/bbc_front.sv
// ============================================================================
// Box blur front end
// Tracks the raster position, classifies each pixel and queues it.
// ============================================================================
module bbc_front #(
  parameter int MAX_WIDTH = bbc_pkg::MAX_WIDTH_DEF,
  parameter int RADIUS    = bbc_pkg::RADIUS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        restart,
  input  logic [bbc_pkg::WID_W-1:0]   cfg_width,
  input  logic [bbc_pkg::HGT_W-1:0]   cfg_height,
  input  logic                        in_push,
  input  logic [bbc_pkg::PIX_W-1:0]   in_red,
  input  logic [bbc_pkg::PIX_W-1:0]   in_green,
  input  logic [bbc_pkg::PIX_W-1:0]   in_blue,
  input  logic                        q_full,
  output logic                        q_push,
  output logic [bbc_pkg::FLAGS_W + $clog2((2*RADIUS+1)*MAX_WIDTH)
                + $clog2(MAX_WIDTH) + 3*bbc_pkg::PIX_W - 1:0] q_data
);

  localparam int D     = 2 * RADIUS + 1;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int EW    = COL_W + 1;
  localparam int LA_W  = $clog2(D * MAX_WIDTH);
  localparam int SL_W  = $clog2(D);
  localparam int HW    = bbc_pkg::HGT_W;

  logic [COL_W-1:0]          c_r;
  logic [bbc_pkg::ROW_W-1:0] r_r;
  logic [LA_W-1:0]           base_r;
  logic [SL_W-1:0]           slot_r;
  logic [EW-1:0]             eff_w, c1;
  logic [HW-1:0]             eff_h, r1;
  logic                      accept;
  bbc_pkg::bbc_flags_t       flags;
  logic [LA_W-1:0]           laddr;

  always_comb begin
    if (cfg_width == '0) begin
      eff_w = EW'(1);
    end else if (32'(cfg_width) > MAX_WIDTH) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(cfg_width);
    end
    if (cfg_height == '0) begin
      eff_h = HW'(1);
    end else if (32'(cfg_height) > bbc_pkg::MAX_HEIGHT) begin
      eff_h = HW'(bbc_pkg::MAX_HEIGHT);
    end else begin
      eff_h = cfg_height;
    end
  end

  assign accept = in_push & ~q_full;
  assign c1     = EW'(c_r) + EW'(1);
  assign r1     = HW'(r_r) + HW'(1);
  assign laddr  = base_r + LA_W'(c_r);

  always_comb begin
    flags.row_first = (r_r == '0);
    flags.row_full  = (HW'(r_r) >= HW'(D));
    flags.col_first = (c_r == '0);
    flags.col_full  = (EW'(c_r) >= EW'(D));
    flags.emit      = (c1 >= EW'(D)) && (r1 >= HW'(D));
    flags.frame_end = (c1 == eff_w) && (r1 == eff_h);
  end

  assign q_push = accept;
  assign q_data = {flags, laddr, c_r, in_blue, in_green, in_red};

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      c_r    <= '0;
      r_r    <= '0;
      base_r <= '0;
      slot_r <= '0;
    end else if (accept) begin
      if (c1 >= eff_w) begin
        c_r <= '0;
        if (r1 >= eff_h) begin
          r_r    <= '0;
          base_r <= '0;
          slot_r <= '0;
        end else begin
          r_r <= r1[bbc_pkg::ROW_W-1:0];
          // The line store is a ring of D rows.
          if (slot_r == SL_W'(D - 1)) begin
            slot_r <= '0;
            base_r <= '0;
          end else begin
            slot_r <= slot_r + SL_W'(1);
            base_r <= base_r + LA_W'(MAX_WIDTH);
          end
        end
      end else begin
        c_r <= c1[COL_W-1:0];
      end
    end
  end

endmodule

FILE: rtl/bbc_back.sv
// ============================================================================
// Box blur back end
// Updates column and window sums, divides by the window area, queues words.
// ============================================================================
module bbc_back #(
  parameter int MAX_WIDTH = bbc_pkg::MAX_WIDTH_DEF,
  parameter int RADIUS    = bbc_pkg::RADIUS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  output logic                        q_pop,
  input  logic [bbc_pkg::FLAGS_W + $clog2((2*RADIUS+1)*MAX_WIDTH)
                + $clog2(MAX_WIDTH) + 3*bbc_pkg::PIX_W - 1:0] q_data,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [bbc_pkg::PIX_W-1:0]   out_red,
  output logic [bbc_pkg::PIX_W-1:0]   out_green,
  output logic [bbc_pkg::PIX_W-1:0]   out_blue,
  output logic                        out_frame_end
);

  localparam int PW    = bbc_pkg::PIX_W;
  localparam int D     = 2 * RADIUS + 1;
  localparam int AREA  = D * D;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int LA_W  = $clog2(D * MAX_WIDTH);
  localparam int CS_W  = $clog2(D * 255 + 1);
  localparam int WS_W  = $clog2(AREA * 255 + 1);
  localparam int DIV_S = $clog2(64'(255) * AREA * AREA) + 1;
  localparam logic [63:0] RECIP = ((64'd1 << DIV_S) + 64'(AREA) - 64'd1) / 64'(AREA);
  localparam int RC_W  = DIV_S - $clog2(AREA) + 2;
  localparam int PR_W  = WS_W + RC_W;
  localparam int OUT_W = 3 * PW + 1;
  localparam int OC_W  = $clog2(bbc_pkg::OUT_DEPTH) + 1;

  // Stage A: issue from the queue and read both memories.
  logic                issue;
  logic [3*PW-1:0]     a_px;
  logic [COL_W-1:0]    a_col;
  logic [LA_W-1:0]     a_la;
  bbc_pkg::bbc_flags_t a_fl;
  logic [OC_W-1:0]     oc;

  // Stage B: column sum update.
  logic                b_v_r;
  logic [3*PW-1:0]     b_px_r;
  logic [COL_W-1:0]    b_col_r;
  bbc_pkg::bbc_flags_t b_fl_r;
  logic [3*PW-1:0]     b_old;
  logic [3*CS_W-1:0]   b_cs_rd, b_cs, b_new;
  logic                pb_v_r;
  logic [COL_W-1:0]    pb_col_r;
  logic [3*CS_W-1:0]   pb_sum_r;

  // Stage C: window sums.
  logic                c_v_r;
  logic [3*CS_W-1:0]   c_new_r;
  bbc_pkg::bbc_flags_t c_fl_r;
  logic [3*CS_W-1:0]   dl_r [D];
  logic [WS_W-1:0]     win_r [3];
  logic [WS_W-1:0]     win_nxt [3];

  // Stage D: reciprocal multiply.
  logic                d_v_r;
  bbc_pkg::bbc_flags_t d_fl_r;

  // Stage E: quotient and queue write.
  logic                e_v_r;
  bbc_pkg::bbc_flags_t e_fl_r;
  logic [PR_W-1:0]     e_prod_r [3];
  logic [PW-1:0]       e_q [3];
  logic [OUT_W-1:0]    out_wdata, out_rdata;

  assign {a_fl, a_la, a_col, a_px} = q_data;

  // Room is reserved for every word that could still be in the pipeline.
  assign issue = ~q_empty &&
                 (32'(oc) + bbc_pkg::PIPE_STAGES + 1 <= bbc_pkg::OUT_DEPTH);
  assign q_pop = issue;

  bbc_ram #(.WIDTH(3 * PW), .DEPTH(D * MAX_WIDTH)) u_line_ram (
    .clk   (clk),
    .we    (issue),
    .waddr (a_la),
    .wdata (a_px),
    .raddr (a_la),
    .rdata (b_old)
  );

  bbc_ram #(.WIDTH(3 * CS_W), .DEPTH(MAX_WIDTH)) u_col_ram (
    .clk   (clk),
    .we    (b_v_r),
    .waddr (b_col_r),
    .wdata (b_new),
    .raddr (a_col),
    .rdata (b_cs_rd)
  );

  // A column written in the previous cycle was read before the write landed.
  assign b_cs = (pb_v_r && pb_col_r == b_col_r) ? pb_sum_r : b_cs_rd;

  always_comb begin
    logic [CS_W-1:0] base;
    logic [CS_W-1:0] cur;
    base  = '0;
    cur   = '0;
    b_new = '0;
    for (int k = 0; k < 3; k++) begin
      cur = b_cs[k*CS_W +: CS_W];
      if (b_fl_r.row_first) begin
        base = '0;
      end else if (b_fl_r.row_full) begin
        base = cur - CS_W'(b_old[k*PW +: PW]);
      end else begin
        base = cur;
      end
      b_new[k*CS_W +: CS_W] = base + CS_W'(b_px_r[k*PW +: PW]);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (c_fl_r.col_first) begin
        win_nxt[k] = WS_W'(c_new_r[k*CS_W +: CS_W]);
      end else if (c_fl_r.col_full) begin
        win_nxt[k] = win_r[k] + WS_W'(c_new_r[k*CS_W +: CS_W])
                     - WS_W'(dl_r[D-1][k*CS_W +: CS_W]);
      end else begin
        win_nxt[k] = win_r[k] + WS_W'(c_new_r[k*CS_W +: CS_W]);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e_q[k] = PW'(e_prod_r[k] >> DIV_S);
    end
  end

  assign out_wdata = {e_fl_r.frame_end, e_q[2], e_q[1], e_q[0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r  <= 1'b0;
      pb_v_r <= 1'b0;
      c_v_r  <= 1'b0;
      d_v_r  <= 1'b0;
      e_v_r  <= 1'b0;
    end else begin
      b_v_r  <= issue;
      pb_v_r <= b_v_r;
      c_v_r  <= b_v_r;
      d_v_r  <= c_v_r;
      e_v_r  <= d_v_r;
    end
  end

  always_ff @(posedge clk) begin
    b_px_r   <= a_px;
    b_col_r  <= a_col;
    b_fl_r   <= a_fl;
    pb_col_r <= b_col_r;
    pb_sum_r <= b_new;
    c_new_r  <= b_new;
    c_fl_r   <= b_fl_r;
    d_fl_r   <= c_fl_r;
    e_fl_r   <= d_fl_r;
    if (c_v_r) begin
      dl_r[0] <= c_new_r;
      for (int i = 1; i < D; i++) begin
        dl_r[i] <= dl_r[i-1];
      end
      for (int k = 0; k < 3; k++) begin
        win_r[k] <= win_nxt[k];
      end
    end
    for (int k = 0; k < 3; k++) begin
      e_prod_r[k] <= PR_W'(win_r[k]) * PR_W'(RECIP[RC_W-1:0]);
    end
  end

  bbc_fifo #(.WIDTH(OUT_W), .DEPTH(bbc_pkg::OUT_DEPTH)) u_out_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (e_v_r & e_fl_r.emit),
    .wdata (out_wdata),
    .full  (),
    .pop   (out_pop),
    .rdata (out_rdata),
    .empty (out_empty),
    .count (oc)
  );

  assign {out_frame_end, out_blue, out_green, out_red} = out_rdata;

endmodule

FILE: rtl/box_blur_cropped_core.sv
// Throughput: one pixel per cycle, held by the read-modify-write of the column-sum RAM,
// while the result queue has room for every word that may still be in the pipeline.
// A pixel is taken whenever the front queue has room; results wait in an 8-word queue.
// Reset is synchronous and active low: position counters and queues clear, sizes go to
// 640 by 480. The memories are not cleared; each entry is written before it is read.
// ============================================================================
// Cropped box blur core
// RGB raster in, truncated window means of every full window out.
// ============================================================================
module box_blur_cropped_core #(
  parameter int MAX_WIDTH = bbc_pkg::MAX_WIDTH_DEF,
  parameter int RADIUS    = bbc_pkg::RADIUS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bbc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bbc_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [bbc_pkg::PIX_W-1:0]     in_red_in,
  input  logic [bbc_pkg::PIX_W-1:0]     in_green_in,
  input  logic [bbc_pkg::PIX_W-1:0]     in_blue_in,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [bbc_pkg::PIX_W-1:0]     out_red_out,
  output logic [bbc_pkg::PIX_W-1:0]     out_green_out,
  output logic [bbc_pkg::PIX_W-1:0]     out_blue_out,
  output logic                          out_frame_end
);

  localparam int D      = 2 * RADIUS + 1;
  localparam int ITEM_W = bbc_pkg::FLAGS_W + $clog2(D * MAX_WIDTH)
                          + $clog2(MAX_WIDTH) + 3 * bbc_pkg::PIX_W;

  logic [bbc_pkg::WID_W-1:0] width_r;
  logic [bbc_pkg::HGT_W-1:0] height_r;
  logic                      restart;
  logic                      mq_push, mq_pop, mq_empty;
  logic [ITEM_W-1:0]         mq_wdata, mq_rdata;

  // Any write to a known register restarts the frame.
  assign restart = cfg_we &&
                   (cfg_index == bbc_pkg::CFG_IMAGE_WIDTH ||
                    cfg_index == bbc_pkg::CFG_IMAGE_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= bbc_pkg::WIDTH_RESET;
      height_r <= bbc_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bbc_pkg::CFG_IMAGE_WIDTH:  width_r  <= cfg_data[bbc_pkg::WID_W-1:0];
        bbc_pkg::CFG_IMAGE_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  bbc_front #(.MAX_WIDTH(MAX_WIDTH), .RADIUS(RADIUS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .restart    (restart),
    .cfg_width  (width_r),
    .cfg_height (height_r),
    .in_push    (in_push),
    .in_red     (in_red_in),
    .in_green   (in_green_in),
    .in_blue    (in_blue_in),
    .q_full     (in_full),
    .q_push     (mq_push),
    .q_data     (mq_wdata)
  );

  bbc_fifo #(.WIDTH(ITEM_W), .DEPTH(bbc_pkg::MID_DEPTH)) u_mid_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mq_push),
    .wdata (mq_wdata),
    .full  (in_full),
    .pop   (mq_pop),
    .rdata (mq_rdata),
    .empty (mq_empty),
    .count ()
  );

  bbc_back #(.MAX_WIDTH(MAX_WIDTH), .RADIUS(RADIUS)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (mq_empty),
    .q_pop         (mq_pop),
    .q_data        (mq_rdata),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_red       (out_red_out),
    .out_green     (out_green_out),
    .out_blue      (out_blue_out),
    .out_frame_end (out_frame_end)
  );

endmodule

FILE: rtl/bbc_checker.sv
// ============================================================================
// Box blur port checker
// Watches the top-level ports of the box blur core over time.
// ============================================================================
`include "assert_macros.svh"

module bbc_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_full,
  input logic                      out_empty,
  input logic                      out_pop,
  input logic [bbc_pkg::PIX_W-1:0] out_red_out,
  input logic [bbc_pkg::PIX_W-1:0] out_green_out,
  input logic [bbc_pkg::PIX_W-1:0] out_blue_out,
  input logic                      out_frame_end
);

  // Reset leaves no result word behind.
  `BBC_ASSERT_RST(a_rst_empty, clk, !rst_n, out_empty, "result queue not empty after reset")
  // Reset leaves room for input.
  `BBC_ASSERT_RST(a_rst_room, clk, !rst_n, !in_full, "input full after reset")
  // A waiting word that is not taken stays put.
  `BBC_ASSERT_NXT(a_hold, clk, rst_n, !out_empty && !out_pop,
                  !out_empty && $stable(out_red_out) && $stable(out_green_out) &&
                  $stable(out_blue_out) && $stable(out_frame_end),
                  "waiting result word changed")
  // An end-of-frame word that is shown has a red value no larger than 255.
  `BBC_ASSERT_IMP(a_fe_known, clk, rst_n, !out_empty && out_frame_end,
                  out_red_out <= 8'd255, "frame end word out of range")

endmodule

bind box_blur_cropped_core bbc_checker u_bbc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_full       (in_full),
  .out_empty     (out_empty),
  .out_pop       (out_pop),
  .out_red_out   (out_red_out),
  .out_green_out (out_green_out),
  .out_blue_out  (out_blue_out),
  .out_frame_end (out_frame_end)
);
